>>> hdl/trdn_pkg.sv
package trdn_pkg;

  // telnet command and option codes
  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;

  localparam logic [7:0] OPT_BINARY   = 8'd0;
  localparam logic [7:0] OPT_TTYPE    = 8'd24;
  localparam logic [7:0] OPT_EOR      = 8'd25;
  localparam logic [7:0] OPT_ENVIRON  = 8'd39;
  localparam logic [7:0] OPT_STARTTLS = 8'd46;

  // result kinds
  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_SB_END  = 3'd2;
  localparam logic [2:0] KIND_NEG     = 3'd3;
  localparam logic [2:0] KIND_CMD     = 3'd4;

  // queue between parser and executor
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // parser phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_OPT    = 2'd2
  } phase_t;

  // classified operation handed from parser to executor
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_CMD  = 2'd1,
    OP_NEG  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   op;
    logic [7:0] value;
    logic [7:0] opt;
  } op_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [7:0] option_code;
    logic       reply_valid;
    logic [7:0] reply_cmd;
    logic [7:0] reply_opt;
    logic       binary_done;
    logic       eor_done;
  } res_t;

endpackage

>>> hdl/trdn_front.sv
module trdn_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  output logic           push,
  output trdn_pkg::op_t  push_op
);

  trdn_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       held_r, held_nxt;

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= trdn_pkg::PH_NORMAL;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // held command waiting for its option byte
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      phase_nxt = trdn_pkg::PH_NORMAL;
      unique case (phase_r)
        trdn_pkg::PH_ESC: begin
          if (rx_byte != trdn_pkg::CODE_IAC && rx_byte >= trdn_pkg::CODE_SB) begin
            phase_nxt = trdn_pkg::PH_OPT;
            held_nxt  = rx_byte;
          end
        end
        trdn_pkg::PH_OPT: begin
          phase_nxt = trdn_pkg::PH_NORMAL;
        end
        default: begin
          if (rx_byte == trdn_pkg::CODE_IAC) begin
            phase_nxt = trdn_pkg::PH_ESC;
          end
        end
      endcase
    end
  end

  // classification of the accepted byte
  always_comb begin
    push          = 1'b0;
    push_op.op    = trdn_pkg::OP_BYTE;
    push_op.value = rx_byte;
    push_op.opt   = 8'd0;
    unique case (phase_r)
      trdn_pkg::PH_ESC: begin
        if (rx_byte == trdn_pkg::CODE_IAC) begin
          push = accept;
        end else if (rx_byte < trdn_pkg::CODE_SB) begin
          push       = accept;
          push_op.op = trdn_pkg::OP_CMD;
        end
      end
      trdn_pkg::PH_OPT: begin
        push          = accept;
        push_op.op    = trdn_pkg::OP_NEG;
        push_op.value = held_r;
        push_op.opt   = rx_byte;
      end
      default: begin
        push = accept && (rx_byte != trdn_pkg::CODE_IAC);
      end
    endcase
  end

  a_iac_escapes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == trdn_pkg::PH_NORMAL && rx_byte == trdn_pkg::CODE_IAC
      |=> phase_r == trdn_pkg::PH_ESC)
    else $error("iac in normal phase did not enter escape");

  a_opt_returns: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == trdn_pkg::PH_OPT |-> push && push_op.op == trdn_pkg::OP_NEG)
    else $error("option byte did not produce a negotiation");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("push without an accepted byte");

endmodule

>>> hdl/trdn_queue.sv
module trdn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  trdn_pkg::op_t  push_op,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output trdn_pkg::op_t  head_op
);

  trdn_pkg::op_t                  entry_r [trdn_pkg::QDEPTH];
  logic [trdn_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [trdn_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [trdn_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full       = (count_r == trdn_pkg::QCNT_W'(trdn_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == trdn_pkg::QPTR_W'(trdn_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == trdn_pkg::QPTR_W'(trdn_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= trdn_pkg::QCNT_W'(trdn_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

>>> hdl/trdn_back.sv
module trdn_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  trdn_pkg::op_t   head_op,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output trdn_pkg::res_t  out_res
);

  logic           out_valid_r;
  trdn_pkg::res_t res_r, res_nxt;
  logic           sub_r, sub_nxt;
  logic [7:0]     sub_opt_r, sub_opt_nxt;
  logic           binary_r, binary_nxt;
  logic           eor_r, eor_nxt;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // execute the head operation
  always_comb begin
    sub_nxt     = sub_r;
    sub_opt_nxt = sub_opt_r;
    binary_nxt  = binary_r;
    eor_nxt     = eor_r;
    res_nxt.kind        = sub_r ? trdn_pkg::KIND_PAYLOAD : trdn_pkg::KIND_DATA;
    res_nxt.byte_value  = head_op.value;
    res_nxt.option_code = 8'd0;
    res_nxt.reply_valid = 1'b0;
    res_nxt.reply_cmd   = 8'd0;
    res_nxt.reply_opt   = 8'd0;
    unique case (head_op.op)
      trdn_pkg::OP_CMD: begin
        if (head_op.value == trdn_pkg::CODE_SE && sub_r) begin
          res_nxt.kind        = trdn_pkg::KIND_SB_END;
          res_nxt.option_code = sub_opt_r;
          sub_nxt             = 1'b0;
        end else begin
          res_nxt.kind = trdn_pkg::KIND_CMD;
        end
      end
      trdn_pkg::OP_NEG: begin
        res_nxt.kind        = trdn_pkg::KIND_NEG;
        res_nxt.option_code = head_op.opt;
        if (head_op.value == trdn_pkg::CODE_WILL) begin
          if (head_op.opt == trdn_pkg::OPT_BINARY) begin
            res_nxt.reply_valid = 1'b1;
            res_nxt.reply_cmd   = trdn_pkg::CODE_DO;
            binary_nxt          = 1'b1;
          end else if (head_op.opt == trdn_pkg::OPT_EOR) begin
            res_nxt.reply_valid = 1'b1;
            res_nxt.reply_cmd   = trdn_pkg::CODE_DO;
            eor_nxt             = 1'b1;
          end else if (head_op.opt != trdn_pkg::OPT_STARTTLS) begin
            res_nxt.reply_valid = 1'b1;
            res_nxt.reply_cmd   = trdn_pkg::CODE_DONT;
          end
        end else if (head_op.value == trdn_pkg::CODE_DO) begin
          res_nxt.reply_valid = 1'b1;
          if (head_op.opt == trdn_pkg::OPT_BINARY) begin
            res_nxt.reply_cmd = trdn_pkg::CODE_WILL;
            binary_nxt        = 1'b1;
          end else if (head_op.opt == trdn_pkg::OPT_EOR) begin
            res_nxt.reply_cmd = trdn_pkg::CODE_WILL;
            eor_nxt           = 1'b1;
          end else if (head_op.opt == trdn_pkg::OPT_TTYPE ||
                       head_op.opt == trdn_pkg::OPT_ENVIRON) begin
            res_nxt.reply_cmd = trdn_pkg::CODE_WILL;
          end else begin
            res_nxt.reply_cmd = trdn_pkg::CODE_WONT;
          end
        end else if (head_op.value == trdn_pkg::CODE_SB) begin
          sub_nxt     = 1'b1;
          sub_opt_nxt = head_op.opt;
        end
        if (res_nxt.reply_valid) begin
          res_nxt.reply_opt = head_op.opt;
        end
      end
      default: begin
      end
    endcase
    res_nxt.binary_done = binary_nxt;
    res_nxt.eor_done    = eor_nxt;
  end

  // negotiation state, updated per executed operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r     <= 1'b0;
      sub_opt_r <= 8'd0;
      binary_r  <= 1'b0;
      eor_r     <= 1'b0;
    end else if (pop) begin
      sub_r     <= sub_nxt;
      sub_opt_r <= sub_opt_nxt;
      binary_r  <= binary_nxt;
      eor_r     <= eor_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  a_reply_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.reply_valid |-> res_r.kind == trdn_pkg::KIND_NEG)
    else $error("reply on a non-negotiation result");

  a_binary_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    binary_r |=> binary_r)
    else $error("binary flag cleared");

  a_eor_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    eor_r |=> eor_r)
    else $error("eor flag cleared");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pop && res_nxt.kind == trdn_pkg::KIND_SB_END |=> !sub_r)
    else $error("subnegotiation still open after its end");

endmodule

>>> hdl/telnet_rx_deframer_negotiator.sv
// a completing byte is queued, then its result is held in the output register
// one byte per cycle unless stalled; parser and executor each take one byte a cycle
// a two-entry queue between parser and executor absorbs output stalls
// iac bytes that open an escape and commands awaiting an option byte give no result
// reset (rst_n low, synchronous) returns the parser to normal phase, empties the queue,
// closes any subnegotiation and clears the binary and eor flags
module telnet_rx_deframer_negotiator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic [7:0] out_option_code,
  output logic       out_reply_valid,
  output logic [7:0] out_reply_cmd,
  output logic [7:0] out_reply_opt,
  output logic       out_binary_done,
  output logic       out_eor_done
);

  logic           accept;
  logic           push;
  trdn_pkg::op_t  push_op;
  logic           q_full;
  logic           head_valid;
  trdn_pkg::op_t  head_op;
  logic           pop;
  trdn_pkg::res_t res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte parser
  trdn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .push_op (push_op)
  );

  // operation queue
  trdn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // negotiation executor and output register
  trdn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (res)
  );

  assign out_kind        = res.kind;
  assign out_byte_value  = res.byte_value;
  assign out_option_code = res.option_code;
  assign out_reply_valid = res.reply_valid;
  assign out_reply_cmd   = res.reply_cmd;
  assign out_reply_opt   = res.reply_opt;
  assign out_binary_done = res.binary_done;
  assign out_eor_done    = res.eor_done;

endmodule
